### design/pitrap_pkg.sv
// pitrap_pkg: shared types, register codes and saturation helpers for the
// PI controller with trapezoidal integration. No dependencies.
package pitrap_pkg;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_SETPOINT        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_P          = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_I          = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INTEGRAL_NONNEG = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_NONNEG   = 3'd4;

  localparam logic signed [63:0] S64_MAX = 64'sh7fff_ffff_ffff_ffff;
  localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;

  typedef struct packed {
    logic signed [31:0] setpoint;
    logic signed [31:0] gain_p;
    logic signed [31:0] gain_i;
    logic               integral_nonneg;
    logic               output_nonneg;
  } cfg_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EVAL,
    S_SUM,
    S_MINC,
    S_ACC,
    S_MLO,
    S_MHI,
    S_COMB,
    S_DRIVE
  } state_t;

  // operand selection of the shared multiplier
  typedef enum logic [1:0] {
    MUL_INC,
    MUL_PROP,
    MUL_LO,
    MUL_HI
  } mul_sel_t;

  typedef struct packed {
    logic     load_in;
    logic     eval;
    logic     sum;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     acc;
    logic     save_prop;
    logic     save_lo;
    logic     combine;
    logic     out_load;
  } dp_cmd_t;

  // saturate a 67 bit signed value to 64 bits
  function automatic logic signed [63:0] sat_s67(input logic signed [66:0] v);
    logic same;
    same = (v[66:63] == 4'b0000) || (v[66:63] == 4'b1111);
    if (same) return v[63:0];
    return v[66] ? S64_MIN : S64_MAX;
  endfunction

  // saturate an 80 bit signed value to 64 bits
  function automatic logic signed [63:0] sat_s80(input logic signed [79:0] v);
    logic same;
    same = (v[79:63] == 17'h0_0000) || (v[79:63] == 17'h1_ffff);
    if (same) return v[63:0];
    return v[79] ? S64_MIN : S64_MAX;
  endfunction

  // 64 bit signed add with saturation
  function automatic logic signed [63:0] add_sat64(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) return s[64] ? S64_MIN : S64_MAX;
    return s[63:0];
  endfunction

endpackage

### design/pitrap_regs.sv
// pitrap_regs: configuration register file written through the cfg channel.
// Depends on pitrap_pkg.
module pitrap_regs (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [pitrap_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [31:0]                          cfg_data,
  output pitrap_pkg::cfg_t                     cfg
);

  // always able to take a write
  assign cfg_ready = 1'b1;

  // register decode, unknown indexes ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        pitrap_pkg::REG_SETPOINT:        cfg.setpoint        <= $signed(cfg_data);
        pitrap_pkg::REG_GAIN_P:          cfg.gain_p          <= $signed(cfg_data);
        pitrap_pkg::REG_GAIN_I:          cfg.gain_i          <= $signed(cfg_data);
        pitrap_pkg::REG_INTEGRAL_NONNEG: cfg.integral_nonneg <= cfg_data[0];
        pitrap_pkg::REG_OUTPUT_NONNEG:   cfg.output_nonneg   <= cfg_data[0];
        default: ;
      endcase
    end
  end

endmodule

### design/pitrap_ctrl.sv
// pitrap_ctrl: sequencer that steps the datapath through one item and owns
// the input stall and output valid. Depends on pitrap_pkg.
module pitrap_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  output logic                 out_valid,
  input  logic                 out_stall,
  output pitrap_pkg::dp_cmd_t  cmd
);

  pitrap_pkg::state_t state, state_next;
  logic out_free;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != pitrap_pkg::S_IDLE);

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pitrap_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      pitrap_pkg::S_IDLE:  if (in_valid) state_next = pitrap_pkg::S_EVAL;
      pitrap_pkg::S_EVAL:  state_next = pitrap_pkg::S_SUM;
      pitrap_pkg::S_SUM:   state_next = pitrap_pkg::S_MINC;
      pitrap_pkg::S_MINC:  state_next = pitrap_pkg::S_ACC;
      pitrap_pkg::S_ACC:   state_next = pitrap_pkg::S_MLO;
      pitrap_pkg::S_MLO:   state_next = pitrap_pkg::S_MHI;
      pitrap_pkg::S_MHI:   state_next = pitrap_pkg::S_COMB;
      pitrap_pkg::S_COMB:  state_next = pitrap_pkg::S_DRIVE;
      pitrap_pkg::S_DRIVE: if (out_free) state_next = pitrap_pkg::S_IDLE;
      default:             state_next = pitrap_pkg::S_IDLE;
    endcase
  end

  // datapath commands
  always_comb begin
    cmd = '0;
    cmd.mul_sel = pitrap_pkg::MUL_INC;
    unique case (state)
      pitrap_pkg::S_IDLE: cmd.load_in = in_valid;
      pitrap_pkg::S_EVAL: cmd.eval = 1'b1;
      pitrap_pkg::S_SUM:  cmd.sum = 1'b1;
      pitrap_pkg::S_MINC: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = pitrap_pkg::MUL_INC;
      end
      pitrap_pkg::S_ACC: begin
        cmd.acc     = 1'b1;
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = pitrap_pkg::MUL_PROP;
      end
      pitrap_pkg::S_MLO: begin
        cmd.save_prop = 1'b1;
        cmd.mul_en    = 1'b1;
        cmd.mul_sel   = pitrap_pkg::MUL_LO;
      end
      pitrap_pkg::S_MHI: begin
        cmd.save_lo = 1'b1;
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = pitrap_pkg::MUL_HI;
      end
      pitrap_pkg::S_COMB:  cmd.combine = 1'b1;
      pitrap_pkg::S_DRIVE: cmd.out_load = out_free;
      default: ;
    endcase
  end

  // output valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule

### design/pitrap_dp.sv
// pitrap_dp: error, trapezoid integral and PI term datapath around one shared
// 34x34 signed multiplier, plus the output registers. Depends on pitrap_pkg.
module pitrap_dp (
  input  logic                       clk,
  input  logic                       rst,
  input  pitrap_pkg::cfg_t           cfg,
  input  pitrap_pkg::dp_cmd_t        cmd,
  input  logic signed [31:0]         measured_temp,
  input  logic [31:0]                time_stamp,
  output logic signed [63:0]         drive_out,
  output logic signed [63:0]         prop_term,
  output logic signed [63:0]         integ_term
);

  // item registers
  logic signed [31:0] meas;
  logic [31:0]        now;
  logic signed [32:0] err;
  logic [31:0]        dt;
  logic               adv;
  logic signed [33:0] sum;

  // controller state
  logic signed [63:0] error_integral;
  logic signed [32:0] prev_error;
  logic [31:0]        prev_time;
  logic               started;

  // multiplier and partial results
  logic signed [33:0] mul_a, mul_b;
  logic signed [67:0] prod;
  logic signed [64:0] p_lo;
  logic signed [63:0] prop;
  logic signed [63:0] integ;

  logic signed [63:0] inc;
  logic signed [63:0] integral_sum;
  logic signed [63:0] integral_next;
  logic signed [95:0] full;
  logic signed [63:0] drive_sum;

  // input capture
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      meas <= measured_temp;
      now  <= time_stamp;
    end
  end

  // error, time step and advance flag
  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      err <= {cfg.setpoint[31], cfg.setpoint} - {meas[31], meas};
      dt  <= now - prev_time;
      adv <= started && (now > prev_time);
    end
  end

  // error sum; first item uses its own error as the previous one
  always_ff @(posedge clk) begin
    if (cmd.sum) begin
      sum <= {err[32], err} + (started ? {prev_error[32], prev_error} : {err[32], err});
    end
  end

  // state carried from item to item
  always_ff @(posedge clk) begin
    if (rst) begin
      error_integral <= '0;
      prev_error     <= '0;
      prev_time      <= '0;
      started        <= 1'b0;
    end else begin
      if (cmd.sum) begin
        prev_error <= err;
        prev_time  <= now;
        started    <= 1'b1;
      end
      if (cmd.acc) begin
        error_integral <= integral_next;
      end
    end
  end

  // shared multiplier operand select
  always_comb begin
    unique case (cmd.mul_sel)
      pitrap_pkg::MUL_INC: begin
        mul_a = $signed({2'b00, dt});
        mul_b = sum;
      end
      pitrap_pkg::MUL_PROP: begin
        mul_a = {{2{cfg.gain_p[31]}}, cfg.gain_p};
        mul_b = {err[32], err};
      end
      pitrap_pkg::MUL_LO: begin
        mul_a = {{2{cfg.gain_i[31]}}, cfg.gain_i};
        mul_b = $signed({2'b00, error_integral[31:0]});
      end
      pitrap_pkg::MUL_HI: begin
        mul_a = {{2{cfg.gain_i[31]}}, cfg.gain_i};
        mul_b = {{2{error_integral[63]}}, error_integral[63:32]};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod <= mul_a * mul_b;
    end
  end

  // trapezoid increment: floor half of dt * sum, saturated, then accumulated
  always_comb begin
    inc          = pitrap_pkg::sat_s67(prod[67:1]);
    integral_sum = adv ? pitrap_pkg::add_sat64(error_integral, inc) : error_integral;
    if (cfg.integral_nonneg && integral_sum[63]) begin
      integral_next = '0;
    end else begin
      integral_next = integral_sum;
    end
  end

  // proportional product and low partial product of the integral term
  always_ff @(posedge clk) begin
    if (cmd.save_prop) prop <= prod[63:0];
    if (cmd.save_lo)   p_lo <= prod[64:0];
  end

  // combine high and low partial products, drop 16 fraction bits, saturate
  assign full = $signed({prod[63:0], 32'h0000_0000}) + {{31{p_lo[64]}}, p_lo};

  always_ff @(posedge clk) begin
    if (cmd.combine) begin
      integ <= pitrap_pkg::sat_s80(full[95:16]);
    end
  end

  // output sum with optional clamp at zero
  assign drive_sum = pitrap_pkg::add_sat64(prop, integ);

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      drive_out  <= (cfg.output_nonneg && drive_sum[63]) ? 64'sd0 : drive_sum;
      prop_term  <= prop;
      integ_term <= integ;
    end
  end

endmodule

### design/pi_controller_trapezoid_integral.sv
// PI temperature controller with trapezoidal error integration.
// Items go through eval, sum, minc, acc, mlo, mhi, comb and drive; the single
// 34x34 multiplier is used four times per item (increment, P term, two halves
// of the I term). A new item is taken only in idle, after the last has been
// loaded into the output register, where it waits while the next item runs.
// Reset (rst, synchronous): clears config, integral, previous error/time.
module pi_controller_trapezoid_integral (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [pitrap_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [31:0]                          cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [31:0]                   measured_temp,
  input  logic [31:0]                          time_stamp,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [63:0]                   drive_out,
  output logic signed [63:0]                   prop_term,
  output logic signed [63:0]                   integ_term
);

  pitrap_pkg::cfg_t    cfg;
  pitrap_pkg::dp_cmd_t cmd;

  pitrap_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  pitrap_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  pitrap_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .cmd           (cmd),
    .measured_temp (measured_temp),
    .time_stamp    (time_stamp),
    .drive_out     (drive_out),
    .prop_term     (prop_term),
    .integ_term    (integ_term)
  );

endmodule

### dv/tb.sv
`timescale 1ns / 100ps
// tb: self-checking bench for pi_controller_trapezoid_integral.
// Depends on pitrap_pkg and the controller RTL. A scoreboard class predicts every
// result and compares it against what the block returns.
module tb;

  localparam int unsigned IDX_W = pitrap_pkg::CFG_IDX_W;
  localparam logic signed [31:0] Q16_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] Q16_MAX = 32'sh7fff_ffff;
  localparam int unsigned SETTLE_CYCLES = 16;
  localparam int unsigned HOLD_CYCLES = 80;
  localparam int unsigned ITEMS_PER_SETTING = 145;

  typedef struct packed {
    logic signed [63:0] drive;
    logic signed [63:0] prop;
    logic signed [63:0] integ;
  } pi_result_t;

  // predictor of the controller plus the queue of results still due
  class pi_tracker;
    logic signed [31:0] setpoint, gain_p, gain_i;
    logic               integ_clamp, drive_clamp;
    logic signed [63:0] integral;
    logic signed [32:0] last_error;
    logic [31:0]        last_time;
    bit                 primed;
    pi_result_t         due_results[$];
    int                 errors, checked, accepted;

    function new();
      setpoint = '0;
      gain_p = '0;
      gain_i = '0;
      integ_clamp = 1'b0;
      drive_clamp = 1'b0;
      integral = '0;
      last_error = '0;
      last_time = '0;
      primed = 0;
    endfunction

    function void write_reg(input logic [IDX_W-1:0] idx, input logic [31:0] data);
      case (idx)
        pitrap_pkg::REG_SETPOINT:        setpoint = data;
        pitrap_pkg::REG_GAIN_P:          gain_p = data;
        pitrap_pkg::REG_GAIN_I:          gain_i = data;
        pitrap_pkg::REG_INTEGRAL_NONNEG: integ_clamp = data[0];
        pitrap_pkg::REG_OUTPUT_NONNEG:   drive_clamp = data[0];
        default: ;
      endcase
    endfunction

    // floor(a * b / 2^sh), limited to the signed 64 bit range
    function logic signed [63:0] mul_shift_sat(input logic signed [63:0] a, b,
                                               input int unsigned sh);
      logic signed [127:0] wa, wb, wide;
      wa = a;
      wb = b;
      wide = (wa * wb) >>> sh;
      if (wide > pitrap_pkg::S64_MAX) return pitrap_pkg::S64_MAX;
      if (wide < pitrap_pkg::S64_MIN) return pitrap_pkg::S64_MIN;
      return wide[63:0];
    endfunction

    function logic signed [63:0] sum_sat(input logic signed [63:0] a, b);
      logic signed [64:0] s;
      s = a + b;
      if (s > pitrap_pkg::S64_MAX) return pitrap_pkg::S64_MAX;
      if (s < pitrap_pkg::S64_MIN) return pitrap_pkg::S64_MIN;
      return s[63:0];
    endfunction

    // one accepted item: advance the integral and queue the result it causes
    function void take_sample(input logic signed [31:0] meas, input logic [31:0] ts);
      logic signed [32:0] err;
      logic signed [33:0] esum;
      logic signed [63:0] dt;
      pi_result_t r;
      accepted++;
      err = setpoint - meas;
      // first item after reset integrates nothing
      if (!primed) begin
        primed = 1;
        last_time = ts;
        last_error = err;
      end
      // trapezoid step only when time moved forward
      if (ts > last_time) begin
        dt = {32'd0, ts - last_time};
        esum = err + last_error;
        integral = sum_sat(integral, mul_shift_sat(dt, esum, 1));
      end
      if (integ_clamp && integral < 0) integral = '0;
      r.integ = mul_shift_sat(gain_i, integral, 16);
      r.prop = gain_p * err;
      r.drive = sum_sat(r.prop, r.integ);
      if (drive_clamp && r.drive < 0) r.drive = '0;
      last_error = err;
      last_time = ts;
      due_results.push_back(r);
    endfunction

    function void check_result(input logic signed [63:0] drive, prop, integ);
      pi_result_t want;
      logic [63:0] got_v[3];
      logic [63:0] want_v[3];
      string tag[3];
      if (due_results.size() == 0) begin
        errors++;
        if (errors <= 40)
          $display("%0t: result with nothing expected, expected none, actual %h %h %h",
                   $time, drive, prop, integ);
        return;
      end
      want = due_results.pop_front();
      checked++;
      got_v = '{drive, prop, integ};
      want_v = '{want.drive, want.prop, want.integ};
      tag = '{"drive_out", "prop_term", "integ_term"};
      for (int k = 0; k < 3; k++) begin
        if (got_v[k] !== want_v[k]) begin
          errors++;
          if (errors <= 40)
            $display("%0t: %s mismatch, expected %h, actual %h",
                     $time, tag[k], want_v[k], got_v[k]);
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [31:0] measured_temp = '0;
  logic [31:0] time_stamp = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [63:0] drive_out, prop_term, integ_term;

  pi_tracker tracker = new();
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int settings_done = 0;
  logic rx_hold = 1'b0;
  bit pressure_go = 0;
  logic [31:0] cur_time = '0;

  pi_controller_trapezoid_integral i_dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .measured_temp(measured_temp), .time_stamp(time_stamp),
    .out_valid(out_valid), .out_stall(out_stall),
    .drive_out(drive_out), .prop_term(prop_term), .integ_term(integ_term)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver pacing
  always @(posedge clk) begin
    out_stall <= rx_hold || ($urandom_range(0, 99) < rx_idle_pct);
  end

  // long output hold so the block backs up and stalls its input
  initial begin
    wait (pressure_go);
    @(posedge clk);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rx_hold <= 1'b0;
  end

  // observe register writes, accepted items and results
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) tracker.write_reg(cfg_index, cfg_data);
      if (in_valid && !in_stall) tracker.take_sample(measured_temp, time_stamp);
      if (out_valid && !out_stall) tracker.check_result(drive_out, prop_term, integ_term);
    end
  end

  function automatic logic signed [31:0] rand_q16();
    case ($urandom_range(0, 5))
      0: return Q16_MIN;
      1: return Q16_MAX;
      2: return $urandom();
      default: return int'($urandom_range(0, 1 << 21)) - (1 << 20);
    endcase
  endfunction

  // write all registers back to back, plus one unused index
  task automatic program_regs(input logic [31:0] sp, gp, gi, input logic inn, onn);
    logic [IDX_W-1:0] idx[6];
    logic [31:0] val[6];
    idx = '{pitrap_pkg::REG_SETPOINT, pitrap_pkg::REG_GAIN_P, pitrap_pkg::REG_GAIN_I,
            pitrap_pkg::REG_INTEGRAL_NONNEG, pitrap_pkg::REG_OUTPUT_NONNEG,
            pitrap_pkg::REG_OUTPUT_NONNEG + IDX_W'($urandom_range(1, 3))};
    val = '{sp, gp, gi, {31'($urandom()), inn}, {31'($urandom()), onn}, $urandom()};
    for (int k = 0; k < 6; k++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[k];
      cfg_data <= val[k];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    cfg_valid <= 1'b0;
    settings_done++;
  endtask

  // stop offering items and let every result drain
  task automatic settle();
    in_valid <= 1'b0;
    for (int k = 0; k < 20000 && tracker.due_results.size() != 0; k++) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic send_item(input logic signed [31:0] meas, input logic [31:0] ts);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    measured_temp <= meas;
    time_stamp <= ts;
    cur_time = ts;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // mostly advancing time near the setpoint, some jumps, repeats and rewinds
  task automatic send_random_item();
    logic [31:0] ts;
    logic signed [31:0] meas;
    case ($urandom_range(0, 9))
      0: ts = $urandom();
      1: ts = cur_time;
      2: ts = cur_time - $urandom_range(1, 1 << 20);
      default: ts = cur_time + $urandom_range(1, 1 << 18);
    endcase
    case ($urandom_range(0, 7))
      0: meas = $urandom();
      1: meas = $urandom_range(0, 1) ? Q16_MAX : Q16_MIN;
      default: meas = tracker.setpoint + (int'($urandom_range(0, 1 << 21)) - (1 << 20));
    endcase
    send_item(meas, ts);
  endtask

  initial begin
    int tx_pace[3];
    int rx_pace[3];
    tx_pace = '{11, 70, 0};
    rx_pace = '{70, 11, 0};
    tx_idle_pct = tx_pace[0];
    rx_idle_pct = rx_pace[0];
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset configuration, first item seeds the previous error and time
    send_item(32'sh0012_0000, 32'h0001_0000);
    send_item(32'shffff_ffff, 32'h0002_0000);
    settle();

    // moderate gains: field extremes, repeated, rewound and wrapped time
    program_regs(32'h0014_0000, 32'h0001_0000, 32'h0000_8000, 1'b0, 1'b0);
    send_item(Q16_MAX, 32'h0003_0000);
    send_item(Q16_MIN, 32'h0004_0000);
    send_item(32'sh0014_0000, 32'h0004_0000);
    send_item(32'sh0010_0000, 32'h0002_0000);
    send_item(32'sh0018_0000, 32'h0000_0000);
    send_item(32'sh0012_0000, 32'hffff_ffff);
    send_item(32'sh0015_0000, 32'hffff_ffff);
    settle();

    // extreme gains, integral and outputs driven into saturation
    program_regs(Q16_MIN, Q16_MAX, Q16_MAX, 1'b0, 1'b0);
    send_item(Q16_MAX, 32'h0000_0000);
    send_item(Q16_MAX, 32'hffff_ffff);
    send_item(Q16_MIN, 32'h0000_0000);
    send_item(Q16_MAX, 32'h8000_0000);
    settle();

    // both clamps on with opposite extreme gains
    program_regs(Q16_MAX, Q16_MIN, Q16_MIN, 1'b1, 1'b1);
    send_item(Q16_MIN, 32'h0000_1000);
    send_item(Q16_MIN, 32'hffff_0000);
    send_item(32'sh7000_0000, 32'h0000_0000);
    settle();

    // negative integral clamped, negative output passed through
    program_regs(32'h0000_0000, 32'h0001_0000, 32'h0001_0000, 1'b1, 1'b0);
    send_item(32'sh0100_0000, 32'h0001_0000);
    send_item(32'sh0100_0000, 32'h0005_0000);
    settle();

    // random part in three pacing mixes, reconfigured between bursts
    for (int phase = 0; phase < 3; phase++) begin
      tx_idle_pct = tx_pace[phase];
      rx_idle_pct = rx_pace[phase];
      for (int burst = 0; burst < 3; burst++) begin
        program_regs(rand_q16(), rand_q16(), rand_q16(), 1'($urandom_range(0, 1)),
                     1'($urandom_range(0, 1)));
        if (phase == 2 && burst == 0) pressure_go = 1;
        repeat (ITEMS_PER_SETTING) send_random_item();
        settle();
      end
    end

    // anything still queued never came back
    if (tracker.due_results.size() != 0) begin
      tracker.errors += tracker.due_results.size();
      $display("%0t: results missing, expected %0d more, actual 0",
               $time, tracker.due_results.size());
    end
    $display("covered %0d items and %0d results over %0d register settings,", tracker.accepted,
             tracker.checked, settings_done);
    $display("three pacing mixes and one long output hold; %0d mismatches", tracker.errors);
    if (tracker.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
